// File: sv/ntcbt_pkg.sv
// Shared constants, types and helpers for the NTC beta temperature unit.
package ntcbt_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 28;

  localparam int RES_W  = 20;   // resistor registers
  localparam int BETA_W = 14;
  localparam int CFG_W  = 20;   // widest register
  localparam int IDX_W  = 2;
  localparam int TEMP_W = 11;

  localparam logic [IDX_W-1:0] CFG_SERIES  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_NOMINAL = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BETA    = 2'd2;

  localparam logic [RES_W-1:0]  SERIES_RST  = 20'd10000;
  localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
  localparam logic [BETA_W-1:0] BETA_RST    = 14'd3950;

  localparam logic [TEMP_W-1:0] TEMP_LOW_CLAMP  = 11'h6EF;  // -273
  localparam logic [TEMP_W-1:0] TEMP_HIGH_CLAMP = 11'd1023;
  localparam logic [TEMP_W-1:0] TEMP_ZERO_CODE  = 11'h7D8;  // -40
  localparam logic [TEMP_W-1:0] TEMP_FULL_CODE  = 11'd125;
  localparam int               TEMP_LOW_MAG    = 273;
  localparam int               TEMP_HIGH_MAG   = 1023;

  localparam logic [63:0] LN2_Q64   = 64'hB17217F7D1CF79AB;
  localparam int          ZERO_C_CK = 27315;   // 273.15 K in hundredths
  localparam int          T25_CK    = 29815;   // 298.15 K in hundredths

  typedef enum logic [3:0] {
    S_IDLE,
    S_PA,
    S_PB,
    S_NORM,
    S_DY,
    S_MY2,
    S_MT,
    S_DT,
    S_LN,
    S_DBL,
    S_DB,
    S_DD,
    S_MK,
    S_DN,
    S_FIN
  } state_t;

  // odd series divisor for term index 0,1,2
  function automatic logic [2:0] term_div(input logic [1:0] k);
    case (k)
      2'd0:    term_div = 3'd3;
      2'd1:    term_div = 3'd5;
      default: term_div = 3'd7;
    endcase
  endfunction

endpackage

// File: sv/ntcbt_if.sv
// Stream interfaces for sample beats and temperature beats.
interface ntcbt_in_if #(
  parameter int SAMPLE_W = ntcbt_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ntcbt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ntcbt_pkg::TEMP_W-1:0] temp_celsius;
  logic                               saturated;
  modport source (output valid, output temp_celsius, output saturated, input ready);
  modport sink   (input valid, input temp_celsius, input saturated, output ready);
endinterface

// File: sv/ntc_beta_temperature_unit.sv
// NTC thermistor beta-equation temperature unit, shared shift-add multiplier and divider.
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     adc_sample [ADC_BITS]
//  out_ch    out  valid/ready     temp_celsius [11] signed, saturated
//  cfg_*     in   cfg_we only     cfg_index [2], cfg_data [20]
//
// A sample runs from the accept cycle to the result load through PA, PB, NORM (one
// step per normalizing shift), the series, log and division states, and FIN.
// The time is set by one bit-serial multiplier (FRAC_BITS steps,
// five products) and one restoring divider (one quotient bit per cycle, six quotients).
// Zero and full-scale samples skip the arithmetic and go straight to FIN.
// in_ch.ready is high only while idle; one result register lets the next sample
// start while a result beat waits. Synchronous active-low reset clears control.
module ntc_beta_temperature_unit #(
  parameter int ADC_BITS  = ntcbt_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = ntcbt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ntcbt_in_if.sink                      in_ch,
  ntcbt_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [ntcbt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ntcbt_pkg::CFG_W-1:0]   cfg_data
);

  localparam int AB  = ADC_BITS;
  localparam int Q   = FRAC_BITS;
  localparam int RW0 = ntcbt_pkg::RES_W;
  localparam int ABW = RW0 + AB;
  localparam int EW  = $clog2(ABW + 1) + 1;
  localparam int LNW = Q + 7;
  localparam int PW  = ((2 * Q > Q + 21) ? 2 * Q : Q + 21) + 1;
  localparam int NW  = Q + 22;
  localparam int RW  = (ABW + 2 > Q + 14) ? ABW + 2 : Q + 14;
  localparam int CW  = $clog2(NW + 1);
  localparam int TW  = ntcbt_pkg::TEMP_W;

  localparam logic [63:0] LN2Q64 =
    (ntcbt_pkg::LN2_Q64 + (64'd1 << (63 - Q))) >> (64 - Q);
  localparam logic [63:0] INV64 =
    ((64'd100 << Q) + 64'(ntcbt_pkg::T25_CK / 2)) / 64'(ntcbt_pkg::T25_CK);
  localparam logic [Q-1:0]   LN2Q    = LN2Q64[Q-1:0];
  localparam logic [LNW-1:0] INV_T25 = INV64[LNW-1:0];
  localparam logic [NW:0]    ONE_CK  = (NW + 1)'(64'd100 << Q);
  localparam logic [AB-1:0]  FULL    = {AB{1'b1}};

  ntcbt_pkg::state_t state_r, state_nxt;

  logic [RW0-1:0]                series_r, nominal_r;
  logic [ntcbt_pkg::BETA_W-1:0]  beta_r;
  logic [RW0-1:0]                ser_nz, nom_nz;
  logic [ntcbt_pkg::BETA_W-1:0]  beta_nz;

  logic [AB-1:0]  s_r, s_nxt;
  logic [ABW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  logic           yneg_r, yneg_nxt;
  logic [Q-1:0]   ymag_r, ymag_nxt, y2_r, y2_nxt, t_r, t_nxt;
  logic [Q:0]     smag_r, smag_nxt;
  logic [1:0]     k_r, k_nxt;
  logic [LNW-1:0] lnx_r, lnx_nxt, d_r, d_nxt;
  logic           nneg_r, nneg_nxt;
  logic [TW-1:0]  res_r, res_nxt;
  logic           rsat_r, rsat_nxt;

  logic [PW-1:0]  mc_r, mc_nxt, acc_r, acc_nxt;
  logic [Q-1:0]   mp_r, mp_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [RW-2:0]  dv_r, dv_nxt;
  logic [NW-1:0]  nsh_r, nsh_nxt, q_r, q_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  logic           ov_r, ov_nxt;
  logic [TW-1:0]  otemp_r, otemp_nxt;
  logic           osat_r, osat_nxt;

  // shared step units
  logic [RW-1:0]  rem_sh;
  logic           q_bit;
  logic           unit_done;
  logic [ABW:0]   ab_sum;
  logic [ABW-1:0] ab_diff;
  logic [EW-1:0]  e_mag;
  logic [LNW-1:0] e_prod;
  logic [LNW-1:0] two_s, e_term, lnx_mag, qsel;
  logic [NW:0]    num_w;
  logic [RW-2:0]  d_ext;
  logic           take_out;

  assign ser_nz  = (series_r == '0)  ? RW0'(1) : series_r;
  assign nom_nz  = (nominal_r == '0) ? RW0'(1) : nominal_r;
  assign beta_nz = (beta_r == '0)    ? ntcbt_pkg::BETA_W'(1) : beta_r;

  assign rem_sh    = {rem_r[RW-2:0], nsh_r[NW-1]};
  assign q_bit     = (rem_sh >= {1'b0, dv_r});
  assign unit_done = (cnt_r == '0);
  assign ab_sum    = {1'b0, a_r} + {1'b0, b_r};
  assign ab_diff   = (a_r < b_r) ? (b_r - a_r) : (a_r - b_r);
  assign e_mag     = e_r[EW-1] ? (EW'(0) - e_r) : e_r;
  assign e_prod    = LNW'(e_mag) * LNW'(LN2Q);
  assign two_s     = yneg_r ? (LNW'(0) - LNW'({smag_r, 1'b0})) : LNW'({smag_r, 1'b0});
  assign e_term    = e_r[EW-1] ? (LNW'(0) - e_prod) : e_prod;
  assign lnx_mag   = lnx_r[LNW-1] ? (LNW'(0) - lnx_r) : lnx_r;
  assign qsel      = lnx_r[LNW-1] ? (LNW'(0) - q_r[LNW-1:0]) : q_r[LNW-1:0];
  assign num_w     = ONE_CK - (NW + 1)'(acc_r);
  assign d_ext     = (RW - 1)'(d_r);
  assign take_out  = out_ch.valid && out_ch.ready;

  assign in_ch.ready         = (state_r == ntcbt_pkg::S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.temp_celsius = otemp_r;
  assign out_ch.saturated    = osat_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ntcbt_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.adc_sample == '0 || in_ch.adc_sample == FULL) state_nxt = ntcbt_pkg::S_FIN;
          else state_nxt = ntcbt_pkg::S_PA;
        end
      end
      ntcbt_pkg::S_PA: state_nxt = ntcbt_pkg::S_PB;
      ntcbt_pkg::S_PB: state_nxt = ntcbt_pkg::S_NORM;
      ntcbt_pkg::S_NORM: begin
        if (!({1'b0, a_r} >= {b_r, 1'b0}) && !({a_r, 1'b0} < {1'b0, b_r}))
          state_nxt = ntcbt_pkg::S_DY;
      end
      ntcbt_pkg::S_DY:  if (unit_done) state_nxt = ntcbt_pkg::S_MY2;
      ntcbt_pkg::S_MY2: if (unit_done) state_nxt = ntcbt_pkg::S_MT;
      ntcbt_pkg::S_MT:  if (unit_done) state_nxt = ntcbt_pkg::S_DT;
      ntcbt_pkg::S_DT: begin
        if (unit_done) state_nxt = (k_r == 2'd2) ? ntcbt_pkg::S_LN : ntcbt_pkg::S_MT;
      end
      ntcbt_pkg::S_LN:  state_nxt = ntcbt_pkg::S_DBL;
      ntcbt_pkg::S_DBL: state_nxt = ntcbt_pkg::S_DB;
      ntcbt_pkg::S_DB:  if (unit_done) state_nxt = ntcbt_pkg::S_DD;
      ntcbt_pkg::S_DD: begin
        if (d_r == '0 || d_r[LNW-1]) state_nxt = ntcbt_pkg::S_FIN;
        else state_nxt = ntcbt_pkg::S_MK;
      end
      ntcbt_pkg::S_MK:  if (unit_done) state_nxt = ntcbt_pkg::S_DN;
      ntcbt_pkg::S_DN:  if (unit_done) state_nxt = ntcbt_pkg::S_FIN;
      ntcbt_pkg::S_FIN: if (!ov_r || out_ch.ready) state_nxt = ntcbt_pkg::S_IDLE;
      default: state_nxt = ntcbt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    s_nxt    = s_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    e_nxt    = e_r;
    yneg_nxt = yneg_r;
    ymag_nxt = ymag_r;
    y2_nxt   = y2_r;
    t_nxt    = t_r;
    smag_nxt = smag_r;
    k_nxt    = k_r;
    lnx_nxt  = lnx_r;
    d_nxt    = d_r;
    nneg_nxt = nneg_r;
    res_nxt  = res_r;
    rsat_nxt = rsat_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    nsh_nxt  = nsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    ov_nxt    = take_out ? 1'b0 : ov_r;
    otemp_nxt = otemp_r;
    osat_nxt  = osat_r;

    // shared units step whenever their count is running
    if (!unit_done) begin
      cnt_nxt = cnt_r - CW'(1);
      case (state_r)
        ntcbt_pkg::S_MY2, ntcbt_pkg::S_MT, ntcbt_pkg::S_MK: begin
          if (mp_r[0]) acc_nxt = acc_r + mc_r;
          mc_nxt = {mc_r[PW-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[Q-1:1]};
        end
        default: begin
          rem_nxt = q_bit ? (rem_sh - {1'b0, dv_r}) : rem_sh;
          q_nxt   = {q_r[NW-2:0], q_bit};
          nsh_nxt = {nsh_r[NW-2:0], 1'b0};
        end
      endcase
    end else begin
      case (state_r)
        ntcbt_pkg::S_IDLE: begin
          if (in_ch.valid) begin
            s_nxt    = in_ch.adc_sample;
            rsat_nxt = 1'b0;
            res_nxt  = (in_ch.adc_sample == '0) ? ntcbt_pkg::TEMP_ZERO_CODE
                                                : ntcbt_pkg::TEMP_FULL_CODE;
          end
        end
        ntcbt_pkg::S_PA: a_nxt = ABW'(ser_nz) * ABW'(s_r);
        ntcbt_pkg::S_PB: begin
          b_nxt = ABW'(FULL - s_r) * ABW'(nom_nz);
          e_nxt = '0;
        end
        ntcbt_pkg::S_NORM: begin
          if ({1'b0, a_r} >= {b_r, 1'b0}) begin
            b_nxt = {b_r[ABW-2:0], 1'b0};
            e_nxt = e_r + EW'(1);
          end else if ({a_r, 1'b0} < {1'b0, b_r}) begin
            a_nxt = {a_r[ABW-2:0], 1'b0};
            e_nxt = e_r - EW'(1);
          end else begin
            // y = |a-b| / (a+b), fraction bits only
            yneg_nxt = (a_r < b_r);
            rem_nxt  = RW'(ab_diff);
            dv_nxt   = (RW - 1)'(ab_sum);
            nsh_nxt  = '0;
            q_nxt    = '0;
            cnt_nxt  = CW'(Q);
          end
        end
        ntcbt_pkg::S_DY: begin
          ymag_nxt = q_r[Q-1:0];
          mc_nxt   = PW'(q_r[Q-1:0]);
          mp_nxt   = q_r[Q-1:0];
          acc_nxt  = '0;
          cnt_nxt  = CW'(Q);
        end
        ntcbt_pkg::S_MY2: begin
          y2_nxt   = acc_r[Q +: Q];
          smag_nxt = (Q + 1)'(ymag_r);
          k_nxt    = 2'd0;
          mc_nxt   = PW'(ymag_r);
          mp_nxt   = acc_r[Q +: Q];
          acc_nxt  = '0;
          cnt_nxt  = CW'(Q);
        end
        ntcbt_pkg::S_MT: begin
          t_nxt   = acc_r[Q +: Q];
          rem_nxt = '0;
          dv_nxt  = (RW - 1)'(ntcbt_pkg::term_div(k_r));
          nsh_nxt = NW'(acc_r[Q +: Q]);
          q_nxt   = '0;
          cnt_nxt = CW'(NW);
        end
        ntcbt_pkg::S_DT: begin
          smag_nxt = smag_r + (Q + 1)'(q_r);
          if (k_r != 2'd2) begin
            k_nxt   = k_r + 2'd1;
            mc_nxt  = PW'(t_r);
            mp_nxt  = y2_r;
            acc_nxt = '0;
            cnt_nxt = CW'(Q);
          end
        end
        ntcbt_pkg::S_LN: lnx_nxt = two_s + e_term;
        ntcbt_pkg::S_DBL: begin
          rem_nxt = '0;
          dv_nxt  = (RW - 1)'(beta_nz);
          nsh_nxt = NW'(lnx_mag);
          q_nxt   = '0;
          cnt_nxt = CW'(NW);
        end
        ntcbt_pkg::S_DB: d_nxt = INV_T25 + qsel;
        ntcbt_pkg::S_DD: begin
          if (d_r == '0) begin
            res_nxt  = ntcbt_pkg::TEMP_HIGH_CLAMP;
            rsat_nxt = 1'b1;
          end else if (d_r[LNW-1]) begin
            res_nxt  = ntcbt_pkg::TEMP_LOW_CLAMP;
            rsat_nxt = 1'b1;
          end else begin
            mc_nxt  = PW'(d_r);
            mp_nxt  = Q'(ntcbt_pkg::ZERO_C_CK);
            acc_nxt = '0;
            cnt_nxt = CW'(Q);
          end
        end
        ntcbt_pkg::S_MK: begin
          // num = 100*2^Q - 27315*d, divided by 100*d as magnitudes
          nneg_nxt = num_w[NW];
          nsh_nxt  = num_w[NW] ? NW'((NW + 1)'(0) - num_w) : num_w[NW-1:0];
          dv_nxt   = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
          rem_nxt  = '0;
          q_nxt    = '0;
          cnt_nxt  = CW'(NW);
        end
        ntcbt_pkg::S_DN: begin
          rsat_nxt = 1'b0;
          if (nneg_r) begin
            if (q_r > NW'(ntcbt_pkg::TEMP_LOW_MAG)) begin
              res_nxt  = ntcbt_pkg::TEMP_LOW_CLAMP;
              rsat_nxt = 1'b1;
            end else begin
              res_nxt = TW'(0) - q_r[TW-1:0];
            end
          end else if (q_r > NW'(ntcbt_pkg::TEMP_HIGH_MAG)) begin
            res_nxt  = ntcbt_pkg::TEMP_HIGH_CLAMP;
            rsat_nxt = 1'b1;
          end else begin
            res_nxt = q_r[TW-1:0];
          end
        end
        ntcbt_pkg::S_FIN: begin
          if (!ov_r || out_ch.ready) begin
            ov_nxt    = 1'b1;
            otemp_nxt = res_r;
            osat_nxt  = rsat_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ntcbt_pkg::S_IDLE;
      cnt_r     <= '0;
      ov_r      <= 1'b0;
      series_r  <= ntcbt_pkg::SERIES_RST;
      nominal_r <= ntcbt_pkg::NOMINAL_RST;
      beta_r    <= ntcbt_pkg::BETA_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ntcbt_pkg::CFG_SERIES:  series_r  <= cfg_data[RW0-1:0];
          ntcbt_pkg::CFG_NOMINAL: nominal_r <= cfg_data[RW0-1:0];
          ntcbt_pkg::CFG_BETA:    beta_r    <= cfg_data[ntcbt_pkg::BETA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    e_r     <= e_nxt;
    yneg_r  <= yneg_nxt;
    ymag_r  <= ymag_nxt;
    y2_r    <= y2_nxt;
    t_r     <= t_nxt;
    smag_r  <= smag_nxt;
    k_r     <= k_nxt;
    lnx_r   <= lnx_nxt;
    d_r     <= d_nxt;
    nneg_r  <= nneg_nxt;
    res_r   <= res_nxt;
    rsat_r  <= rsat_nxt;
    mc_r    <= mc_nxt;
    mp_r    <= mp_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    dv_r    <= dv_nxt;
    nsh_r   <= nsh_nxt;
    q_r     <= q_nxt;
    otemp_r <= otemp_nxt;
    osat_r  <= osat_nxt;
  end

endmodule

// File: dv/tb_ntc_beta_temperature_unit.sv
// Testbench for the NTC beta temperature unit: table-driven and random samples vs. predictor.
`timescale 1ns / 100ps

module tb_ntc_beta_temperature_unit;

  localparam int  FRAC       = ntcbt_pkg::FRAC_BITS_DEF;
  localparam int  FULL_SCALE = (1 << ntcbt_pkg::ADC_BITS_DEF) - 1;
  localparam int  DRAIN_CYC  = 500;
  localparam int  CYCLE_CAP  = 4000000;
  localparam int  RAND_ITEMS = 200;
  localparam int  N_PHASES   = 7;
  localparam int  N_ROWS     = 14;

  typedef struct packed {
    logic signed [ntcbt_pkg::TEMP_W-1:0] temp;
    logic                                sat;
  } temp_beat_t;

  typedef struct {
    logic [ntcbt_pkg::ADC_BITS_DEF-1:0] sample;
    bit                                 known;
    temp_beat_t                         beat;
  } sample_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ntcbt_pkg::IDX_W-1:0] cfg_index;
  logic [ntcbt_pkg::CFG_W-1:0] cfg_data;

  ntcbt_in_if  in_bus ();
  ntcbt_out_if out_bus ();

  ntc_beta_temperature_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus.sink),
    .out_ch   (out_bus.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // register copies
  logic [ntcbt_pkg::RES_W-1:0]  series_r;
  logic [ntcbt_pkg::RES_W-1:0]  nominal_r;
  logic [ntcbt_pkg::BETA_W-1:0] beta_r;

  temp_beat_t pending_temps[$];
  int         fail_count;
  int         cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint unsigned nz(input longint unsigned v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic longint unsigned mul_frac(input longint unsigned x,
                                               input longint unsigned y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[FRAC+63:FRAC];
  endfunction

  function automatic longint unsigned div_frac(input longint unsigned n,
                                               input longint unsigned d);
    longint unsigned rem;
    longint unsigned q;
    rem = n;
    q = 0;
    for (int i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic temp_beat_t beta_temperature(
      input logic [ntcbt_pkg::ADC_BITS_DEF-1:0] s);
    longint unsigned a, b, ymag, y2, t3, t5, t7, smag, ln2q, inv_t25, bk, qmag;
    longint e, sum, lnx, d, num, t;
    bit yneg, sat;
    temp_beat_t r;
    e = 0;
    sat = 1'b0;
    if (s == 0) begin
      r.temp = -11'sd40;
      r.sat = 1'b0;
      return r;
    end
    if (s == FULL_SCALE) begin
      r.temp = 11'sd125;
      r.sat = 1'b0;
      return r;
    end
    a = nz(series_r) * longint'(s);
    b = longint'(FULL_SCALE - s) * nz(nominal_r);
    while (a >= 2 * b) begin
      b = b << 1;
      e++;
    end
    while (2 * a < b) begin
      a = a << 1;
      e--;
    end
    yneg = a < b;
    ymag = div_frac(yneg ? b - a : a - b, a + b);
    y2 = mul_frac(ymag, ymag);
    t3 = mul_frac(ymag, y2);
    t5 = mul_frac(t3, y2);
    t7 = mul_frac(t5, y2);
    smag = ymag + t3 / 3 + t5 / 5 + t7 / 7;
    sum = yneg ? -longint'(smag) : longint'(smag);
    ln2q = (ntcbt_pkg::LN2_Q64 + (64'd1 << (63 - FRAC))) >> (64 - FRAC);
    lnx = 2 * sum + e * longint'(ln2q);
    inv_t25 = ((64'd100 << FRAC) + ntcbt_pkg::T25_CK / 2) / ntcbt_pkg::T25_CK;
    bk = nz(beta_r);
    qmag = longint'(lnx < 0 ? -lnx : lnx) / bk;
    d = longint'(inv_t25) + (lnx < 0 ? -longint'(qmag) : longint'(qmag));
    if (d == 0) begin
      t = ntcbt_pkg::TEMP_HIGH_MAG;
      sat = 1'b1;
    end else if (d < 0) begin
      t = -ntcbt_pkg::TEMP_LOW_MAG;
      sat = 1'b1;
    end else begin
      num = longint'(64'd100 << FRAC) - ntcbt_pkg::ZERO_C_CK * d;
      t = num / (100 * d);
      if (t < -ntcbt_pkg::TEMP_LOW_MAG) begin
        t = -ntcbt_pkg::TEMP_LOW_MAG;
        sat = 1'b1;
      end else if (t > ntcbt_pkg::TEMP_HIGH_MAG) begin
        t = ntcbt_pkg::TEMP_HIGH_MAG;
        sat = 1'b1;
      end
    end
    r.temp = t[ntcbt_pkg::TEMP_W-1:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic cfg_write(input logic [ntcbt_pkg::IDX_W-1:0] idx,
                           input logic [ntcbt_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ntcbt_pkg::CFG_SERIES:  series_r = val[ntcbt_pkg::RES_W-1:0];
      ntcbt_pkg::CFG_NOMINAL: nominal_r = val[ntcbt_pkg::RES_W-1:0];
      ntcbt_pkg::CFG_BETA:    beta_r = val[ntcbt_pkg::BETA_W-1:0];
      default: ;
    endcase
  endtask

  // sender: gap, then hold valid until the beat is taken
  task automatic send_sample(input logic [ntcbt_pkg::ADC_BITS_DEF-1:0] s, input bit known,
                             input temp_beat_t beat);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.adc_sample <= s;
    do @(posedge clk); while (!in_bus.ready);
    pending_temps.push_back(known ? beat : beta_temperature(s));
  endtask

  // drop valid right after the last accepted beat so it is not taken twice
  task automatic drain;
    in_bus.valid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [ntcbt_pkg::ADC_BITS_DEF-1:0] rand_sample;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FULL_SCALE;
      2: return $urandom_range(1, 15);
      3: return $urandom_range(FULL_SCALE - 15, FULL_SCALE - 1);
      default: return $urandom_range(0, FULL_SCALE);
    endcase
  endfunction

  // result side
  initial begin
    int stall;
    temp_beat_t want;
    out_bus.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      if (pending_temps.size() == 0) begin
        $display("%0t: unexpected beat temp=%0d sat=%0b", $time,
                 out_bus.temp_celsius, out_bus.saturated);
        fail_count++;
      end else begin
        want = pending_temps.pop_front();
        if (out_bus.temp_celsius !== want.temp) begin
          $display("%0t: temp_celsius expected %0d actual %0d", $time,
                   want.temp, out_bus.temp_celsius);
          fail_count++;
        end
        if (out_bus.saturated !== want.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time,
                   want.sat, out_bus.saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    sample_row_t rows[N_ROWS];
    logic [ntcbt_pkg::CFG_W-1:0] phase_cfg[N_PHASES][3];
    temp_beat_t none;
    none = '0;
    fail_count = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ntcbt_pkg::CFG_SERIES;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.adc_sample = '0;
    series_r = ntcbt_pkg::SERIES_RST;
    nominal_r = ntcbt_pkg::NOMINAL_RST;
    beta_r = ntcbt_pkg::BETA_RST;

    rows[0]  = '{12'd0, 1, '{ntcbt_pkg::TEMP_ZERO_CODE, 1'b0}};
    rows[1]  = '{12'd4095, 1, '{ntcbt_pkg::TEMP_FULL_CODE, 1'b0}};
    rows[2]  = '{12'd1, 0, none};
    rows[3]  = '{12'd4094, 0, none};
    rows[4]  = '{12'd2048, 0, none};
    rows[5]  = '{12'd2047, 0, none};
    rows[6]  = '{12'd0, 1, '{ntcbt_pkg::TEMP_ZERO_CODE, 1'b0}};
    rows[7]  = '{12'd2, 0, none};
    rows[8]  = '{12'd100, 0, none};
    rows[9]  = '{12'd1000, 0, none};
    rows[10] = '{12'd3000, 0, none};
    rows[11] = '{12'd4000, 0, none};
    rows[12] = '{12'd4095, 1, '{ntcbt_pkg::TEMP_FULL_CODE, 1'b0}};
    rows[13] = '{12'hAAA, 0, none};

    // series, nominal, beta; zero acts as one
    phase_cfg[0] = '{20'd1, 20'd1, 20'd1};
    phase_cfg[1] = '{20'd1000000, 20'd1000000, 20'd10000};
    phase_cfg[2] = '{20'd0, 20'd0, 20'd0};
    phase_cfg[3] = '{20'd1000000, 20'd1, 20'd1};
    phase_cfg[4] = '{20'd1, 20'd1000000, 20'd10000};
    phase_cfg[5] = '{20'd4700, 20'd100000, 20'd3435};
    phase_cfg[6] = '{20'd10000, 20'd10000, 20'd3950};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].beat);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      cfg_write(ntcbt_pkg::CFG_SERIES, phase_cfg[p][0]);
      cfg_write(ntcbt_pkg::CFG_NOMINAL, phase_cfg[p][1]);
      cfg_write(ntcbt_pkg::CFG_BETA, phase_cfg[p][2]);
      // unmapped index must not disturb anything
      cfg_write(2'd3, $urandom_range(0, (1 << ntcbt_pkg::CFG_W) - 1));
      @(posedge clk);
      cfg_we <= 1'b0;
      for (int k = 0; k < RAND_ITEMS; k++) begin
        if (p == 5 && k == RAND_ITEMS / 2) begin
          in_bus.valid <= 1'b0;
          do @(posedge clk); while (pending_temps.size() != 0);
        end
        if (p >= 5 && k % 50 == 49) begin
          drain();
          cfg_write(ntcbt_pkg::CFG_SERIES, $urandom_range(1, 1000000));
          cfg_write(ntcbt_pkg::CFG_NOMINAL, $urandom_range(1, 1000000));
          cfg_write(ntcbt_pkg::CFG_BETA, $urandom_range(1, 10000));
          @(posedge clk);
          cfg_we <= 1'b0;
        end
        send_sample(rand_sample(), 0, none);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
